// ===== hdl/ogu_pkg.sv =====
// Shared types, constants and helper functions for the obstacle guard unit.
`timescale 1ns / 1ps
`default_nettype none
package ogu_pkg;

  localparam int DIST_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int SCALE_FRAC = 8;
  localparam int MARGIN_W   = 34;
  localparam int HALF_W     = 35;
  localparam int POS_W      = 36;
  localparam int EXT_W      = 37;
  localparam int LEN_W      = 31;
  localparam int VAR_K      = (DIST_WIDTH + FRAC_BITS) / 2;
  localparam int SIZE_K     = 32;
  localparam int DIFF_BITS  = DIST_WIDTH + 1;
  localparam int POS_BITS   = POS_W - 1;
  localparam int PROD_W     = 16 + VAR_K;

  localparam logic signed [39:0] DIST_MAX40 = 40'sd2147483647;
  localparam logic signed [39:0] DIST_MIN40 = -40'sd2147483648;
  localparam logic [39:0]        CAP40      = 40'h007FFFFFFF;

  typedef enum logic [1:0] {
    REG_TRACK_LENGTH = 2'd0,
    REG_MIN_LONG     = 2'd1,
    REG_MIN_LAT      = 2'd2,
    REG_SIGMA_SCALE  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] s0;
    logic signed [31:0] s1;
    logic signed [31:0] sc;
    logic signed [31:0] dr;
    logic signed [31:0] dl;
    logic signed [31:0] sz;
  } p1_t;

  typedef struct packed {
    logic signed [31:0]         sc;
    logic signed [31:0]         sz;
    logic signed [31:0]         lo;
    logic signed [31:0]         hi;
    logic signed [MARGIN_W-1:0] lm;
    logic signed [MARGIN_W-1:0] tm;
    logic                       dneg;
  } p2_t;

  typedef struct packed {
    logic               xs_neg;
    logic               xe_neg;
    logic signed [31:0] xs_sat;
    logic signed [31:0] xe_sat;
    logic [63:0]        sum;
    logic signed [31:0] gr;
    logic signed [31:0] gl;
  } p3_t;

  typedef struct packed {
    logic signed [31:0] gs;
    logic signed [31:0] ge;
    logic signed [31:0] gr;
    logic signed [31:0] gl;
  } p4_t;

  function automatic logic signed [31:0] sat_dist(input logic signed [39:0] v);
    if (v > DIST_MAX40) begin
      return 32'sh7FFFFFFF;
    end else if (v < DIST_MIN40) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic [30:0] abs_cap(input logic signed [39:0] v);
    logic [39:0] m;
    m = v[39] ? 40'(-v) : 40'(v);
    return (m > CAP40) ? 31'h7FFFFFFF : m[30:0];
  endfunction

endpackage
`default_nettype wire

// ===== hdl/ogu_sqrt_cell.sv =====
// One digit step of a pipelined integer square root, several lanes side by side.
`timescale 1ns / 1ps
`default_nettype none
module ogu_sqrt_cell #(
  parameter int LANES = 1,
  parameter int K     = 24,
  parameter int PW    = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            en,
  input  wire logic                            valid_i,
  input  wire logic [LANES-1:0][2*K-1:0]       rad_i,
  input  wire logic [LANES-1:0][K+1:0]         rem_i,
  input  wire logic [LANES-1:0][K-1:0]         root_i,
  input  wire logic [PW-1:0]                   pay_i,
  output logic                                 valid_o,
  output logic [LANES-1:0][2*K-1:0]            rad_o,
  output logic [LANES-1:0][K+1:0]              rem_o,
  output logic [LANES-1:0][K-1:0]              root_o,
  output logic [PW-1:0]                        pay_o
);

  logic                      valid_r;
  logic [LANES-1:0][2*K-1:0] rad_r, rad_nxt;
  logic [LANES-1:0][K+1:0]   rem_r, rem_nxt;
  logic [LANES-1:0][K-1:0]   root_r, root_nxt;
  logic [PW-1:0]             pay_r;

  always_comb begin
    logic [K+3:0] sh;
    logic [K+3:0] trial;
    for (int l = 0; l < LANES; l++) begin
      sh    = {rem_i[l], rad_i[l][2*K-1:2*K-2]};
      trial = {2'b00, root_i[l], 2'b01};
      if (sh >= trial) begin
        rem_nxt[l]  = K'(0) + (K+2)'(sh - trial);
        root_nxt[l] = {root_i[l][K-2:0], 1'b1};
      end else begin
        rem_nxt[l]  = sh[K+1:0];
        root_nxt[l] = {root_i[l][K-2:0], 1'b0};
      end
      rad_nxt[l] = {rad_i[l][2*K-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      pay_r  <= pay_i;
    end
  end

  assign valid_o = valid_r;
  assign rad_o   = rad_r;
  assign rem_o   = rem_r;
  assign root_o  = root_r;
  assign pay_o   = pay_r;

endmodule
`default_nettype wire

// ===== hdl/ogu_mod_cell.sv =====
// One bit step of a pipelined restoring modulo by the track length, several lanes.
`timescale 1ns / 1ps
`default_nettype none
module ogu_mod_cell #(
  parameter int LANES = 1,
  parameter int N     = 33,
  parameter int RW    = 31,
  parameter int PW    = 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic [RW-1:0]             len_i,
  input  wire logic                      valid_i,
  input  wire logic [LANES-1:0][N-1:0]   num_i,
  input  wire logic [LANES-1:0][RW-1:0]  rem_i,
  input  wire logic [PW-1:0]             pay_i,
  output logic                           valid_o,
  output logic [LANES-1:0][N-1:0]        num_o,
  output logic [LANES-1:0][RW-1:0]       rem_o,
  output logic [PW-1:0]                  pay_o
);

  logic                       valid_r;
  logic [LANES-1:0][N-1:0]    num_r, num_nxt;
  logic [LANES-1:0][RW-1:0]   rem_r, rem_nxt;
  logic [PW-1:0]              pay_r;

  always_comb begin
    logic [RW:0] t;
    for (int l = 0; l < LANES; l++) begin
      t = {rem_i[l], num_i[l][N-1]};
      if (t >= {1'b0, len_i}) begin
        t = t - {1'b0, len_i};
      end
      rem_nxt[l] = t[RW-1:0];
      num_nxt[l] = {num_i[l][N-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
      pay_r <= pay_i;
    end
  end

  assign valid_o = valid_r;
  assign num_o   = num_r;
  assign rem_o   = rem_r;
  assign pay_o   = pay_r;

endmodule
`default_nettype wire

// ===== hdl/obstacle_uncertainty_guard_unit.sv =====
// Top level of the obstacle guard unit: config registers and the cell pipeline.
//
// Input stream in_*: one obstacle box per transaction, eight signed Q15.16 fields.
// Output stream out_*: one guard box per input, in the same order.
// Config: APB-style port, four registers at byte addresses 0, 4, 8, 12:
//   track length, fixed longitudinal margin, fixed lateral margin, sigma scale.
// The pipeline is a 24-cell square root row for both variances, two
// margin stages, a 33-cell modulo row for the span, three stages for half span,
// bounds and squares, a 35-cell modulo row for both guard ends and a 32-cell
// square root row for the size. One transaction per cycle is sustained.
// The whole pipeline advances together; while out_tvalid is high and out_tready
// is low it holds and in_tready drops, otherwise a new box enters every cycle.
// Reset clears all stage valid bits and restores the register defaults
// (no wrap, zero margins, sigma scale 1.0). Write config only while idle.
`timescale 1ns / 1ps
`default_nettype none
module obstacle_uncertainty_guard_unit
  import ogu_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // start_pos, end_pos, center_pos, right_bound, left_bound, obj_size,
  // long_variance, lat_variance
  input  wire logic [255:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // guard_start, guard_end, outer_right, outer_left, guard_size, zero pad
  output logic [159:0]      out_tdata,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [3:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  logic [LEN_W-1:0]   trk_r;
  logic signed [31:0] mlong_r;
  logic signed [31:0] mlat_r;
  logic [15:0]        scale_r;
  reg_idx_t           cfg_idx;
  logic               cfg_wr;
  logic               en;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trk_r   <= '0;
      mlong_r <= '0;
      mlat_r  <= '0;
      scale_r <= 16'd256;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_TRACK_LENGTH: trk_r   <= cfg_pwdata[30:0];
        REG_MIN_LONG:     mlong_r <= cfg_pwdata;
        REG_MIN_LAT:      mlat_r  <= cfg_pwdata;
        REG_SIGMA_SCALE:  scale_r <= cfg_pwdata[15:0];
        default:          trk_r   <= trk_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_TRACK_LENGTH: cfg_prdata = {1'b0, trk_r};
      REG_MIN_LONG:     cfg_prdata = mlong_r;
      REG_MIN_LAT:      cfg_prdata = mlat_r;
      REG_SIGMA_SCALE:  cfg_prdata = {16'b0, scale_r};
      default:          cfg_prdata = '0;
    endcase
  end

  assign en        = out_tready | ~out_tvalid;
  assign in_tready = en;

  // variance square roots
  localparam int P1W = $bits(p1_t);
  logic [VAR_K:0]                      c1_v;
  logic [VAR_K:0][1:0][2*VAR_K-1:0]    c1_rad;
  logic [VAR_K:0][1:0][VAR_K+1:0]      c1_rem;
  logic [VAR_K:0][1:0][VAR_K-1:0]      c1_root;
  logic [VAR_K:0][P1W-1:0]             c1_pay;
  logic signed [31:0]                  lvar, tvar;
  p1_t                                 p1_in, p1;

  assign lvar  = in_tdata[223:192];
  assign tvar  = in_tdata[255:224];
  assign p1_in = '{s0: in_tdata[31:0], s1: in_tdata[63:32], sc: in_tdata[95:64],
                   dr: in_tdata[127:96], dl: in_tdata[159:128], sz: in_tdata[191:160]};

  assign c1_v[0]      = in_tvalid & in_tready;
  assign c1_rad[0][0] = (lvar > 0) ? {1'b0, lvar[30:0], {FRAC_BITS{1'b0}}} : '0;
  assign c1_rad[0][1] = (tvar > 0) ? {1'b0, tvar[30:0], {FRAC_BITS{1'b0}}} : '0;
  assign c1_rem[0]    = '0;
  assign c1_root[0]   = '0;
  assign c1_pay[0]    = p1_in;

  for (genvar i = 0; i < VAR_K; i++) begin : g_c1
    ogu_sqrt_cell #(.LANES(2), .K(VAR_K), .PW(P1W)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .valid_i(c1_v[i]), .rad_i(c1_rad[i]), .rem_i(c1_rem[i]),
      .root_i(c1_root[i]), .pay_i(c1_pay[i]),
      .valid_o(c1_v[i+1]), .rad_o(c1_rad[i+1]), .rem_o(c1_rem[i+1]),
      .root_o(c1_root[i+1]), .pay_o(c1_pay[i+1])
    );
  end

  assign p1 = p1_t'(c1_pay[VAR_K]);

  // margin products
  logic              m_v_r;
  logic [PROD_W-1:0] m_lprod_r, m_tprod_r;
  p1_t               m_p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else if (en) begin
      m_v_r <= c1_v[VAR_K];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_lprod_r <= PROD_W'(scale_r) * PROD_W'(c1_root[VAR_K][0]);
      m_tprod_r <= PROD_W'(scale_r) * PROD_W'(c1_root[VAR_K][1]);
      m_p_r     <= p1;
    end
  end

  // margins, span difference, lateral order
  logic                         n_v_r;
  logic [DIFF_BITS-1:0]         n_dabs_r;
  p2_t                          n_p_r;
  logic signed [MARGIN_W-1:0]   lm_nxt, tm_nxt;
  logic signed [DIFF_BITS-1:0]  d_nxt;
  p2_t                          p2_nxt;

  always_comb begin
    lm_nxt = MARGIN_W'(mlong_r) + $signed({2'b00, m_lprod_r[PROD_W-1:SCALE_FRAC]});
    tm_nxt = MARGIN_W'(mlat_r) + $signed({2'b00, m_tprod_r[PROD_W-1:SCALE_FRAC]});
    d_nxt  = DIFF_BITS'(m_p_r.s1) - DIFF_BITS'(m_p_r.s0);
    p2_nxt.sc   = m_p_r.sc;
    p2_nxt.sz   = m_p_r.sz;
    p2_nxt.lo   = (m_p_r.dr < m_p_r.dl) ? m_p_r.dr : m_p_r.dl;
    p2_nxt.hi   = (m_p_r.dr < m_p_r.dl) ? m_p_r.dl : m_p_r.dr;
    p2_nxt.lm   = lm_nxt;
    p2_nxt.tm   = tm_nxt;
    p2_nxt.dneg = d_nxt[DIFF_BITS-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_v_r <= 1'b0;
    end else if (en) begin
      n_v_r <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_dabs_r <= d_nxt[DIFF_BITS-1] ? DIFF_BITS'(-d_nxt) : DIFF_BITS'(d_nxt);
      n_p_r    <= p2_nxt;
    end
  end

  // span modulo
  localparam int P2W = $bits(p2_t);
  logic [DIFF_BITS:0]                   c2_v;
  logic [DIFF_BITS:0][0:0][DIFF_BITS-1:0] c2_num;
  logic [DIFF_BITS:0][0:0][LEN_W-1:0]   c2_rem;
  logic [DIFF_BITS:0][P2W-1:0]          c2_pay;

  assign c2_v[0]      = n_v_r;
  assign c2_num[0][0] = n_dabs_r;
  assign c2_rem[0]    = '0;
  assign c2_pay[0]    = n_p_r;

  for (genvar i = 0; i < DIFF_BITS; i++) begin : g_c2
    ogu_mod_cell #(.LANES(1), .N(DIFF_BITS), .RW(LEN_W), .PW(P2W)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .len_i(trk_r),
      .valid_i(c2_v[i]), .num_i(c2_num[i]), .rem_i(c2_rem[i]), .pay_i(c2_pay[i]),
      .valid_o(c2_v[i+1]), .num_o(c2_num[i+1]), .rem_o(c2_rem[i+1]),
      .pay_o(c2_pay[i+1])
    );
  end

  // half span and lateral bounds
  p2_t                       p2;
  logic [LEN_W-1:0]          fwd, rev, smin, r2;
  logic [31:0]               szabs, span;
  logic signed [HALF_W-1:0]  half_nxt;
  logic signed [EXT_W-1:0]   ext_nxt;
  logic signed [POS_W-1:0]   lo_m, hi_p;
  logic                      h_v_r;
  logic signed [HALF_W-1:0]  h_half_r;
  logic signed [31:0]        h_sc_r, h_gr_r, h_gl_r;
  logic signed [EXT_W-1:0]   h_ext_r;

  always_comb begin
    p2    = p2_t'(c2_pay[DIFF_BITS]);
    r2    = c2_rem[DIFF_BITS][0];
    fwd   = (p2.dneg && r2 != '0) ? LEN_W'(trk_r - r2) : r2;
    rev   = (fwd == '0) ? '0 : LEN_W'(trk_r - fwd);
    smin  = (fwd < rev) ? fwd : rev;
    szabs = p2.sz[31] ? 32'(-p2.sz) : 32'(p2.sz);
    span  = (trk_r == '0 || smin == '0) ? szabs : {1'b0, smin};
    half_nxt = $signed({4'b0000, span[31:1]}) + HALF_W'(p2.lm);
    lo_m     = POS_W'(p2.lo) - POS_W'(p2.tm);
    hi_p     = POS_W'(p2.hi) + POS_W'(p2.tm);
    ext_nxt  = EXT_W'(p2.hi) - EXT_W'(p2.lo) + (EXT_W'(p2.tm) <<< 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_v_r <= 1'b0;
    end else if (en) begin
      h_v_r <= c2_v[DIFF_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_half_r <= half_nxt;
      h_sc_r   <= p2.sc;
      h_ext_r  <= ext_nxt;
      h_gr_r   <= sat_dist(40'(lo_m));
      h_gl_r   <= sat_dist(40'(hi_p));
    end
  end

  // guard ends and extents
  logic                     q1_v_r;
  logic signed [POS_W-1:0]  q1_xs_r, q1_xe_r;
  logic [30:0]              q1_a_r, q1_b_r;
  logic signed [31:0]       q1_gr_r, q1_gl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q1_v_r <= 1'b0;
    end else if (en) begin
      q1_v_r <= h_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q1_xs_r <= POS_W'(h_sc_r) - POS_W'(h_half_r);
      q1_xe_r <= POS_W'(h_sc_r) + POS_W'(h_half_r);
      q1_a_r  <= abs_cap(40'(h_half_r) <<< 1);
      q1_b_r  <= abs_cap(40'(h_ext_r));
      q1_gr_r <= h_gr_r;
      q1_gl_r <= h_gl_r;
    end
  end

  // squares
  logic                     q2_v_r;
  logic [61:0]              q2_aa_r, q2_bb_r;
  logic signed [POS_W-1:0]  q2_xs_r, q2_xe_r;
  logic signed [31:0]       q2_gr_r, q2_gl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q2_v_r <= 1'b0;
    end else if (en) begin
      q2_v_r <= q1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q2_aa_r <= 62'(q1_a_r) * 62'(q1_a_r);
      q2_bb_r <= 62'(q1_b_r) * 62'(q1_b_r);
      q2_xs_r <= q1_xs_r;
      q2_xe_r <= q1_xe_r;
      q2_gr_r <= q1_gr_r;
      q2_gl_r <= q1_gl_r;
    end
  end

  // guard end modulo
  localparam int P3W = $bits(p3_t);
  logic [POS_BITS:0]                     c3_v;
  logic [POS_BITS:0][1:0][POS_BITS-1:0]  c3_num;
  logic [POS_BITS:0][1:0][LEN_W-1:0]     c3_rem;
  logic [POS_BITS:0][P3W-1:0]            c3_pay;
  logic [POS_W-1:0]                      xs_abs, xe_abs;
  p3_t                                   p3_in;

  always_comb begin
    xs_abs       = q2_xs_r[POS_W-1] ? POS_W'(-q2_xs_r) : POS_W'(q2_xs_r);
    xe_abs       = q2_xe_r[POS_W-1] ? POS_W'(-q2_xe_r) : POS_W'(q2_xe_r);
    p3_in.xs_neg = q2_xs_r[POS_W-1];
    p3_in.xe_neg = q2_xe_r[POS_W-1];
    p3_in.xs_sat = sat_dist(40'(q2_xs_r));
    p3_in.xe_sat = sat_dist(40'(q2_xe_r));
    p3_in.sum    = 64'(q2_aa_r) + 64'(q2_bb_r);
    p3_in.gr     = q2_gr_r;
    p3_in.gl     = q2_gl_r;
  end

  assign c3_v[0]      = q2_v_r;
  assign c3_num[0][0] = xs_abs[POS_BITS-1:0];
  assign c3_num[0][1] = xe_abs[POS_BITS-1:0];
  assign c3_rem[0]    = '0;
  assign c3_pay[0]    = p3_in;

  for (genvar i = 0; i < POS_BITS; i++) begin : g_c3
    ogu_mod_cell #(.LANES(2), .N(POS_BITS), .RW(LEN_W), .PW(P3W)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .len_i(trk_r),
      .valid_i(c3_v[i]), .num_i(c3_num[i]), .rem_i(c3_rem[i]), .pay_i(c3_pay[i]),
      .valid_o(c3_v[i+1]), .num_o(c3_num[i+1]), .rem_o(c3_rem[i+1]),
      .pay_o(c3_pay[i+1])
    );
  end

  // size square root
  localparam int P4W = $bits(p4_t);
  logic [SIZE_K:0]                       c4_v;
  logic [SIZE_K:0][0:0][2*SIZE_K-1:0]    c4_rad;
  logic [SIZE_K:0][0:0][SIZE_K+1:0]      c4_rem;
  logic [SIZE_K:0][0:0][SIZE_K-1:0]      c4_root;
  logic [SIZE_K:0][P4W-1:0]              c4_pay;
  p3_t                                   p3;
  p4_t                                   p4_in, p4;
  logic [LEN_W-1:0]                      rs, re;
  logic [30:0]                           size;

  always_comb begin
    p3 = p3_t'(c3_pay[POS_BITS]);
    rs = c3_rem[POS_BITS][0];
    re = c3_rem[POS_BITS][1];
    p4_in.gs = (trk_r == '0) ? p3.xs_sat :
               {1'b0, (p3.xs_neg && rs != '0) ? LEN_W'(trk_r - rs) : rs};
    p4_in.ge = (trk_r == '0) ? p3.xe_sat :
               {1'b0, (p3.xe_neg && re != '0) ? LEN_W'(trk_r - re) : re};
    p4_in.gr = p3.gr;
    p4_in.gl = p3.gl;
  end

  assign c4_v[0]      = c3_v[POS_BITS];
  assign c4_rad[0][0] = p3.sum;
  assign c4_rem[0]    = '0;
  assign c4_root[0]   = '0;
  assign c4_pay[0]    = p4_in;

  for (genvar i = 0; i < SIZE_K; i++) begin : g_c4
    ogu_sqrt_cell #(.LANES(1), .K(SIZE_K), .PW(P4W)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .valid_i(c4_v[i]), .rad_i(c4_rad[i]), .rem_i(c4_rem[i]),
      .root_i(c4_root[i]), .pay_i(c4_pay[i]),
      .valid_o(c4_v[i+1]), .rad_o(c4_rad[i+1]), .rem_o(c4_rem[i+1]),
      .root_o(c4_root[i+1]), .pay_o(c4_pay[i+1])
    );
  end

  assign p4   = p4_t'(c4_pay[SIZE_K]);
  assign size = c4_root[SIZE_K][0][SIZE_K-1] ? 31'h7FFFFFFF : c4_root[SIZE_K][0][30:0];

  assign out_tvalid = c4_v[SIZE_K];
  assign out_tdata  = {1'b0, size, p4.gl, p4.gr, p4.ge, p4.gs};

`ifndef SYNTHESIS
  a_start_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && trk_r != '0) |-> (!out_tdata[31] && out_tdata[30:0] < trk_r))
    else $error("guard start outside track");

  a_end_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && trk_r != '0) |-> (!out_tdata[63] && out_tdata[62:32] < trk_r))
    else $error("guard end outside track");

  a_lat_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !mlat_r[31]) |->
      ($signed(out_tdata[95:64]) <= $signed(out_tdata[127:96])))
    else $error("lateral bounds out of order");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |->
      (!in_tready ##1 (out_tvalid && $stable(out_tdata))))
    else $error("pipeline advanced during stall");
`endif

endmodule
`default_nettype wire
